[rtl/core/ssbd_pkg.sv]
// ----------------------------------------------------------------------------
// ssbd_pkg: shared definitions for the seven-segment blink display
// Item types, register indexes, sequencer states and the character table.
// ----------------------------------------------------------------------------
package ssbd_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_MASK = CFG_IDX_W'(1);

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [2:0] digit_index;
        logic       show_point;
        logic [7:0] char_code;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0] out_digit;
        logic [7:0] segments;
        logic       last;
    } t_result_item;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Segment pattern for a character code, point bit clear except for the point character.
    function automatic logic [7:0] glyph_of(input logic [7:0] ch);
        logic [7:0] g;
        case (ch)
            8'h00: g = 8'h3F;
            8'h01: g = 8'h06;
            8'h02: g = 8'h5B;
            8'h03: g = 8'h4F;
            8'h04: g = 8'h66;
            8'h05: g = 8'h6D;
            8'h06: g = 8'h7D;
            8'h07: g = 8'h07;
            8'h08: g = 8'h7F;
            8'h09: g = 8'h6F;
            8'h0A: g = 8'h77;
            8'h0B: g = 8'h7C;
            8'h0C: g = 8'h39;
            8'h0D: g = 8'h5E;
            8'h0E: g = 8'h79;
            8'h0F: g = 8'h71;
            8'h50: g = 8'h73; // P
            8'h48: g = 8'h76; // H
            8'h4C: g = 8'h38; // L
            8'h55: g = 8'h3E; // U
            8'h6E: g = 8'h54; // n
            8'h72: g = 8'h50; // r
            8'h2D: g = 8'h40; // -
            8'h5F: g = 8'h08; // _
            8'h2E: g = 8'h80; // .
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

[rtl/core/ssbd_glyph.sv]
// ----------------------------------------------------------------------------
// ssbd_glyph: character encoder
// Maps a character code to its segment pattern and applies point and polarity.
// ----------------------------------------------------------------------------
module ssbd_glyph (
    input  logic [7:0] i_char_code,
    input  logic       i_show_point,
    input  logic       i_active_low,
    output logic [7:0] o_code
);
    import ssbd_pkg::*;

    logic [7:0] glyph;

    always_comb begin
        glyph = glyph_of(i_char_code);
        if (i_active_low) begin
            // Common anode: a lit segment is a zero, so the point clears bit 7.
            o_code = ~glyph;
            if (i_show_point) begin
                o_code = o_code & 8'h7F;
            end
        end else begin
            o_code = glyph;
            if (i_show_point) begin
                o_code = o_code | 8'h80;
            end
        end
    end

endmodule

[rtl/core/seven_segment_blink_display.sv]
// ----------------------------------------------------------------------------
// seven_segment_blink_display: display buffer with blink
// Stores one segment pattern per digit and scans all digits out on a tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  command   in         start / busy            i_cmd_item (t_cmd_item)
//  result    out        o_strobe, no stall      o_result (t_result_item)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  A set command is stored at its transfer edge and keeps busy low.
//  A tick command holds busy high through the scan, while the scan counter
//  reads one buffer entry per cycle; each result follows in the cycle after.
//  Reset is synchronous: the buffer goes dark and the first tick is lit.
//  The receiver cannot stall, so results leave at the scan rate.
// ----------------------------------------------------------------------------
module seven_segment_blink_display (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ssbd_pkg::t_cmd_item        i_cmd_item,
    output logic                       o_strobe,
    output ssbd_pkg::t_result_item     o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ssbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data
);
    import ssbd_pkg::*;

    t_state     r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic       r_active_low;
    logic [7:0] r_blink_mask;
    logic       r_dark_phase;
    logic [7:0] r_buf [NUM_DIGITS];
    logic       r_strobe;
    t_result_item r_result;

    logic       accept;
    logic       scan_en;
    logic       scan_end;
    logic [7:0] set_code;
    logic [7:0] scan_seg;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    ssbd_glyph u_glyph (
        .i_char_code (i_cmd_item.char_code),
        .i_show_point(i_cmd_item.show_point),
        .i_active_low(r_active_low),
        .o_code      (set_code)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd_item.cmd == CMD_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_W'(NUM_DIGITS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b0;
        scan_en  = 1'b0;
        scan_end = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                busy     = 1'b1;
                scan_en  = 1'b1;
                scan_end = (r_cnt == CNT_W'(NUM_DIGITS - 1));
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // A blinking digit in the dark phase shows the dark pattern of the
    // current polarity, not the stored one.
    always_comb begin
        if (r_dark_phase && r_blink_mask[r_cnt]) begin
            scan_seg = r_active_low ? 8'hFF : 8'h00;
        end else begin
            scan_seg = r_buf[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_active_low <= 1'b0;
            r_blink_mask <= 8'h00;
            r_dark_phase <= 1'b0;
            r_strobe     <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_buf[i] <= 8'h00;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= scan_en;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                    REG_BLINK_MASK: r_blink_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && i_cmd_item.cmd == CMD_SET &&
                {1'b0, i_cmd_item.digit_index} < 4'(NUM_DIGITS)) begin
                r_buf[i_cmd_item.digit_index[CNT_W-1:0]] <= set_code;
            end
            if (scan_en) begin
                if (scan_end) begin
                    r_cnt        <= '0;
                    r_dark_phase <= !r_dark_phase;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_en) begin
            r_result.out_digit <= 3'(r_cnt);
            r_result.segments  <= scan_seg;
            r_result.last      <= scan_end;
        end
    end

endmodule

[rtl/core/ssbd_checker.sv]
// ----------------------------------------------------------------------------
// ssbd_checker: port-level checks for the display
// Watches the command and result channels of the top level over time.
// ----------------------------------------------------------------------------
module ssbd_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  ssbd_pkg::t_cmd_item    i_cmd_item,
    input  logic                   o_strobe,
    input  ssbd_pkg::t_result_item o_result
);
    import ssbd_pkg::*;

    // A tick transfer starts a scan: the sequencer enters ST_SCAN and busy goes high.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd_item.cmd == CMD_TICK) |=> busy)
        else $error("tick transfer did not start a scan");

    // No result directly follows any command transfer.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result in the cycle after a command transfer");

    // Digits of one run come back to back in order.
    a_digit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=>
        (o_strobe && o_result.out_digit == $past(o_result.out_digit) + 3'd1))
        else $error("refresh run broken or out of order");

    // The final digit closes the run.
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |->
        (o_result.out_digit == 3'(NUM_DIGITS - 1)))
        else $error("last flag on the wrong digit");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("result after the last digit");

endmodule

bind seven_segment_blink_display ssbd_checker u_ssbd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_cmd_item(i_cmd_item),
    .o_strobe  (o_strobe),
    .o_result  (o_result)
);

[tb/tb_seven_segment_blink_display.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_segment_blink_display: self-checking bench for the blink display
// Drives set and tick commands with random gaps, reprograms polarity and the
// blink mask between phases, and checks every scanned digit in order against
// a cycle-free model of the digit buffer.
// ----------------------------------------------------------------------------
module tb_seven_segment_blink_display;

    import ssbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 7;
    localparam int PHASE_ITEMS    = 57;

    // Keeps the expected digit contents and the queue of scanned digits.
    class display_scoreboard;
        bit              active_low;
        bit [7:0]        blink_mask;
        bit [7:0]        digit_pat[NUM_DIGITS];
        bit              dark_phase;
        t_result_item    scan_q[$];
        int              errors;

        function new();
            active_low = 1'b0;
            blink_mask = '0;
            dark_phase = 1'b0;
            errors     = 0;
            foreach (digit_pat[i]) digit_pat[i] = 8'h00;
        endfunction

        function bit [7:0] char_pattern(bit [7:0] ch);
            bit [7:0] hex_segs[16] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D,
                                       8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h77, 8'h7C,
                                       8'h39, 8'h5E, 8'h79, 8'h71};
            if (ch < 8'd16) return hex_segs[ch[3:0]];
            case (ch)
                8'h50: return 8'h73; // P
                8'h48: return 8'h76; // H
                8'h4C: return 8'h38; // L
                8'h55: return 8'h3E; // U
                8'h6E: return 8'h54; // n
                8'h72: return 8'h50; // r
                8'h2D: return 8'h40; // -
                8'h5F: return 8'h08; // _
                8'h2E: return 8'h80; // .
                default: return 8'h00;
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == REG_ACTIVE_LOW) active_low = data[0];
            else if (idx == REG_BLINK_MASK) blink_mask = data;
        endfunction

        function void note_command(t_cmd_item c);
            bit [7:0]     pat;
            t_result_item r;
            if (c.cmd == CMD_SET) begin
                pat = char_pattern(c.char_code);
                // Patterns are stored in the polarity in force at the write.
                if (active_low) begin
                    pat = ~pat;
                    if (c.show_point) pat[7] = 1'b0;
                end else if (c.show_point) begin
                    pat[7] = 1'b1;
                end
                if (c.digit_index < NUM_DIGITS) digit_pat[c.digit_index] = pat;
            end else begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    r.out_digit = 3'(i);
                    if (dark_phase && blink_mask[i])
                        r.segments = active_low ? 8'hFF : 8'h00;
                    else
                        r.segments = digit_pat[i];
                    r.last = (i == NUM_DIGITS - 1);
                    scan_q.push_back(r);
                end
                dark_phase = ~dark_phase;
            end
        endfunction

        function void check_result(t_result_item got);
            t_result_item want;
            if (scan_q.size() == 0) begin
                $error("unexpected result: digit %0d segments %02h last %0b",
                       got.out_digit, got.segments, got.last);
                errors++;
                return;
            end
            want = scan_q.pop_front();
            if (got.out_digit !== want.out_digit) begin
                $error("out_digit: expected %0d, actual %0d", want.out_digit, got.out_digit);
                errors++;
            end
            if (got.segments !== want.segments) begin
                $error("segments: expected %02h, actual %02h", want.segments, got.segments);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return scan_q.size();
        endfunction

        function void report_leftover();
            if (scan_q.size() != 0) begin
                $error("%0d scanned digits never arrived", scan_q.size());
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd_item            i_cmd_item;
    logic                 o_strobe;
    t_result_item         o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    display_scoreboard sb;
    int                idle_cycles = 0;

    seven_segment_blink_display u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd_item  (i_cmd_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Observes every transfer at the rising edge and runs the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_result);
            end
            if (start && !busy) begin
                sb.note_command(i_cmd_item);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_command(input t_cmd_item item);
        i_cmd_item <= item;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic send(input logic cmd, input logic [2:0] idx, input logic pt,
                        input logic [7:0] ch);
        t_cmd_item item;
        item.cmd         = cmd;
        item.digit_index = idx;
        item.show_point  = pt;
        item.char_code   = ch;
        push_command(item);
    endtask

    // Both registers go out back to back; valid stays high across the pair.
    task automatic program_display(input bit al, input bit [7:0] mask);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ACTIVE_LOW;
        i_cfg_data  <= {7'b0, al};
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= REG_BLINK_MASK;
        i_cfg_data  <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop issuing, then let the scan finish and the block settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_cmd_item random_command();
        t_cmd_item  item;
        logic [7:0] known_chars[9] = '{8'h50, 8'h48, 8'h4C, 8'h55, 8'h6E,
                                       8'h72, 8'h2D, 8'h5F, 8'h2E};
        int         r;
        item.cmd         = ($urandom_range(0, 3) == 0) ? CMD_TICK : CMD_SET;
        item.digit_index = 3'($urandom_range(0, 7));
        item.show_point  = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r < 4)      item.char_code = 8'($urandom_range(0, 15));
        else if (r < 7) item.char_code = known_chars[$urandom_range(0, 8)];
        else            item.char_code = 8'($urandom_range(0, 255));
        return item;
    endfunction

    initial begin
        bit       phase_al[N_PHASES]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        bit [7:0] phase_mask[N_PHASES] = '{8'h00, 8'h81, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00};
        int       gap;
        bit       no_idle;

        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd_item  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ACTIVE_LOW;
        i_cfg_data  = '0;
        phase_mask[5] = 8'($urandom_range(0, 255));
        phase_mask[6] = 8'($urandom_range(0, 255));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset contents scan dark, then every letter and sign glyph, two hex digits, points and unknown codes.
        send(CMD_TICK, 3'd0, 1'b0, 8'h00);
        send(CMD_SET, 3'd0, 1'b0, 8'h00);
        send(CMD_SET, 3'd1, 1'b1, 8'h0F);
        send(CMD_SET, 3'd2, 1'b0, 8'h50);
        send(CMD_SET, 3'd3, 1'b1, 8'h48);
        send(CMD_SET, 3'd4, 1'b0, 8'h4C);
        send(CMD_SET, 3'd5, 1'b0, 8'h55);
        send(CMD_SET, 3'd6, 1'b0, 8'h6E);
        send(CMD_SET, 3'd7, 1'b1, 8'h72);
        send(CMD_TICK, 3'd7, 1'b1, 8'hFF);
        send(CMD_SET, 3'd0, 1'b0, 8'h2D);
        send(CMD_SET, 3'd1, 1'b1, 8'h5F);
        send(CMD_SET, 3'd2, 1'b0, 8'h2E);
        send(CMD_SET, 3'd3, 1'b1, 8'hFF);
        send(CMD_SET, 3'd4, 1'b0, 8'h10);
        send(CMD_TICK, 3'd0, 1'b0, 8'h00);
        wait_drained();

        // Common anode with everything blinking: old patterns keep their polarity.
        program_display(1'b1, 8'hFF);
        send(CMD_SET, 3'd5, 1'b1, 8'h08);
        send(CMD_SET, 3'd6, 1'b0, 8'hA3);
        send(CMD_TICK, 3'd0, 1'b0, 8'h00);
        send(CMD_TICK, 3'd0, 1'b0, 8'h00);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            program_display(phase_al[p], phase_mask[p]);
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_command(random_command());
                gap = no_idle ? 0 : pick_gap();
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        sb.report_leftover();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
